>>> hdl/g2fb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package g2fb_pkg;

  // Operation codes of a request
  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_FILL = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Lowest channel value that reaches each ink level of (c*3+127)/255
  localparam logic [7:0] INK1_MIN = 8'd43;
  localparam logic [7:0] INK2_MIN = 8'd128;
  localparam logic [7:0] INK3_MIN = 8'd213;

  // Top gray level; gray is this minus the ink level
  localparam logic [1:0] GRAY_MAX = 2'd3;

  // Store address source
  typedef enum logic [1:0] {
    ADDR_PIX,
    ADDR_EVEN,
    ADDR_ODD,
    ADDR_CNT
  } addr_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      latch;
    addr_sel_t addr_sel;
    logic      mem_we;
    logic      wr_fill;
    logic      save_hi;
    logic      load_plane;
    logic      cnt_inc;
    logic      out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit;
    logic cnt_last;
  } stat_t;

  // Quantize the largest channel to a gray level
  function automatic logic [1:0] quantize(input logic [7:0] c);
    logic [1:0] ink;
    ink = (c >= INK3_MIN) ? 2'd3 :
          (c >= INK2_MIN) ? 2'd2 :
          (c >= INK1_MIN) ? 2'd1 : 2'd0;
    return GRAY_MAX - ink;
  endfunction

endpackage

`default_nettype wire

>>> hdl/g2fb_item_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface g2fb_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         white;
  logic               plane;
  logic [15:0]        byte_index;

  modport source (
    output valid, op, x, y, red, green, blue, white, plane, byte_index,
    input  ready
  );
  modport sink (
    input  valid, op, x, y, red, green, blue, white, plane, byte_index,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/g2fb_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface g2fb_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] plane_byte;
  logic       written;
  logic [1:0] gray_level;

  modport source (
    output valid, plane_byte, written, gray_level,
    input  ready
  );
  modport sink (
    input  valid, plane_byte, written, gray_level,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/gray2_framebuffer_bitplane_engine_core.sv
// A draw reads, then writes its byte (S_RD, S_WR); a plane read fetches two
// bytes (S_EVEN, S_ODD), then extracts the plane (S_PLANE); a fill writes each
// byte (S_FILL); clipped draws, out-of-range reads, unused ops skip to S_DONE.
// Only one request is in flight; the single-port frame store sets the pace:
// read-modify-write on draw, two reads per plane read, a write per fill byte.
// Reset clears the controller and result valid only; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module gray2_framebuffer_bitplane_engine_core #(
  parameter int PANEL_WIDTH  = 800,
  parameter int PANEL_HEIGHT = 480
) (
  input wire logic      clk,
  input wire logic      rst,
  g2fb_item_if.sink     item,
  g2fb_result_if.source result
);

  g2fb_pkg::cmd_t  cmd;
  g2fb_pkg::stat_t stat;

  g2fb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_op     (item.op),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  g2fb_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .stat       (stat),
    .op         (item.op),
    .x          (item.x),
    .y          (item.y),
    .red        (item.red),
    .green      (item.green),
    .blue       (item.blue),
    .white      (item.white),
    .plane      (item.plane),
    .byte_index (item.byte_index),
    .plane_byte (result.plane_byte),
    .written    (result.written),
    .gray_level (result.gray_level)
  );

endmodule

`default_nettype wire

>>> hdl/g2fb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module g2fb_datapath #(
  parameter int PANEL_WIDTH  = 800,
  parameter int PANEL_HEIGHT = 480
) (
  input  wire logic               clk,
  input  wire g2fb_pkg::cmd_t     cmd,
  output g2fb_pkg::stat_t         stat,
  input  wire logic [1:0]         op,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  input  wire logic [7:0]         white,
  input  wire logic               plane,
  input  wire logic [15:0]        byte_index,
  output logic [7:0]              plane_byte,
  output logic                    written,
  output logic [1:0]              gray_level
);

  localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 3) / 4;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = AW + 2;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata;

  logic [1:0]    op_r;
  logic          plane_r;
  logic [1:0]    gray;
  logic          hit;
  logic [PW-1:0] pix;
  logic [AW-1:0] even_addr;
  logic [AW-1:0] cnt;
  logic [7:0]    hi;
  logic [7:0]    pbyte;

  logic [7:0]    cmax;
  logic [31:0]   row_base;
  logic [31:0]   pix_full;
  logic [31:0]   even_full;
  logic          draw_in;
  logic          read_in;
  logic [AW-1:0] addr;
  logic [7:0]    wdata;
  logic [7:0]    merged;
  logic [15:0]   pair;
  logic [7:0]    extract;

  // Largest channel, raster index and range checks of the incoming request
  always_comb begin
    cmax = red;
    if (green > cmax) cmax = green;
    if (blue > cmax) cmax = blue;
    if (white > cmax) cmax = white;
    row_base  = {16'd0, y} * 32'(PANEL_WIDTH);
    pix_full  = row_base + {16'd0, x};
    even_full = {15'd0, byte_index, 1'b0};
    draw_in   = (x[15] == 1'b0) && ({16'd0, x} < 32'(PANEL_WIDTH)) &&
                (y[15] == 1'b0) && ({16'd0, y} < 32'(PANEL_HEIGHT));
    read_in   = ({15'd0, byte_index, 1'b1} < 32'(STORE_BYTES));
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r      <= op;
      plane_r   <= plane;
      gray      <= g2fb_pkg::quantize(cmax);
      pix       <= pix_full[PW-1:0];
      even_addr <= even_full[AW-1:0];
      hit       <= (op == g2fb_pkg::OP_DRAW) ? draw_in :
                   (op == g2fb_pkg::OP_READ) ? read_in : 1'b0;
    end
  end

  // Fill sweep counter
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + AW'(1);
    end
  end

  assign stat.hit      = hit;
  assign stat.cnt_last = (cnt == AW'(STORE_BYTES - 1));

  // Select the store address
  always_comb begin
    unique case (cmd.addr_sel)
      g2fb_pkg::ADDR_PIX:  addr = pix[PW-1:2];
      g2fb_pkg::ADDR_EVEN: addr = even_addr;
      g2fb_pkg::ADDR_ODD:  addr = even_addr | AW'(1);
      g2fb_pkg::ADDR_CNT:  addr = cnt;
      default:             addr = cnt;
    endcase
  end

  // Replace the addressed pixel in the byte read back
  always_comb begin
    unique case (pix[1:0])
      2'd0:    merged = {gray, rdata[5:0]};
      2'd1:    merged = {rdata[7:6], gray, rdata[3:0]};
      2'd2:    merged = {rdata[7:4], gray, rdata[1:0]};
      default: merged = {rdata[7:2], gray};
    endcase
    // gray * 0x55 repeats the level in every pixel slot
    wdata = cmd.wr_fill ? {4{gray}} : merged;
  end

  // Frame store, one port, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  // Pick the chosen gray bit of eight pixels
  always_comb begin
    pair = {hi, rdata};
    for (int j = 0; j < 8; j++) begin
      extract[j] = pair[2 * j + (plane_r ? 1 : 0)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_hi) begin
      hi <= rdata;
    end
    if (cmd.latch) begin
      pbyte <= 8'd0;
    end else if (cmd.load_plane) begin
      pbyte <= extract;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      plane_byte <= pbyte;
      written    <= (op_r == g2fb_pkg::OP_DRAW) && hit;
      gray_level <= ((op_r == g2fb_pkg::OP_DRAW) || (op_r == g2fb_pkg::OP_FILL)) ?
                    gray : 2'd0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/g2fb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module g2fb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_op,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output g2fb_pkg::cmd_t       cmd,
  input  wire g2fb_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_EVEN,
    S_ODD,
    S_PLANE,
    S_FILL,
    S_DONE
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Decode commands from state
  always_comb begin
    cmd            = '0;
    cmd.addr_sel   = g2fb_pkg::ADDR_PIX;
    cmd.latch      = accept;
    unique case (state)
      S_IDLE: ;
      S_RD: cmd.addr_sel = g2fb_pkg::ADDR_PIX;
      S_WR: begin
        cmd.addr_sel = g2fb_pkg::ADDR_PIX;
        cmd.mem_we   = 1'b1;
      end
      S_EVEN: cmd.addr_sel = g2fb_pkg::ADDR_EVEN;
      S_ODD: begin
        cmd.addr_sel = g2fb_pkg::ADDR_ODD;
        cmd.save_hi  = 1'b1;
      end
      S_PLANE: cmd.load_plane = 1'b1;
      S_FILL: begin
        cmd.addr_sel = g2fb_pkg::ADDR_CNT;
        cmd.mem_we   = 1'b1;
        cmd.wr_fill  = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      S_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  // Sequence each request and hold the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise result valid on completion, drop it once taken
      out_valid <= ((state == S_DONE) && out_free) || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (in_op == g2fb_pkg::OP_DRAW) begin
              state <= S_RD;
            end else if (in_op == g2fb_pkg::OP_FILL) begin
              state <= S_FILL;
            end else if (in_op == g2fb_pkg::OP_READ) begin
              state <= S_EVEN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RD:    state <= stat.hit ? S_WR : S_DONE;
        S_WR:    state <= S_DONE;
        S_EVEN:  state <= stat.hit ? S_ODD : S_DONE;
        S_ODD:   state <= S_PLANE;
        S_PLANE: state <= S_DONE;
        S_FILL: begin
          if (stat.cnt_last) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/gray2_framebuffer_bitplane_engine_core_tb.sv
`timescale 1ns / 1ps

module gray2_framebuffer_bitplane_engine_core_tb;

  localparam int PANEL_WIDTH  = 800;
  localparam int PANEL_HEIGHT = 480;
  localparam int STORE_BYTES  = (PANEL_WIDTH * PANEL_HEIGHT + 3) / 4;
  localparam int PLANE_BYTES  = STORE_BYTES / 2;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // A fill takes a pass over the whole store; five of them dominate the run
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 625;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         white;
    logic               plane;
    logic [15:0]        byte_index;
  } pixel_req_t;

  typedef struct {
    logic [7:0] plane_byte;
    logic       written;
    logic [1:0] gray_level;
  } pixel_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  g2fb_item_if   item ();
  g2fb_result_if result ();

  gray2_framebuffer_bitplane_engine_core #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  pixel_req_t pending_requests [$];
  pixel_rsp_t expected_results [$];
  logic [7:0] frame_mirror [STORE_BYTES];

  int  send_idle_pct = 38;
  int  recv_idle_pct = 72;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  logic req_fired = 1'b0;

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Gray level of the largest channel: 3 minus the rounded ink level
  function automatic logic [1:0] gray_of(input pixel_req_t r);
    int c;
    int ink;
    c = int'(r.red);
    if (r.green > c) c = int'(r.green);
    if (r.blue > c) c = int'(r.blue);
    if (r.white > c) c = int'(r.white);
    ink = (c * 3 + 127) / 255;
    return g2fb_pkg::GRAY_MAX - ink[1:0];
  endfunction

  // Update the frame mirror and work out the response of one request
  task automatic apply_request(input pixel_req_t r, output pixel_rsp_t rsp);
    int sx;
    int sy;
    int pix;
    int sh;
    int a;
    logic [15:0] w;
    logic [1:0]  g;
    rsp.plane_byte = 8'd0;
    rsp.written    = 1'b0;
    rsp.gray_level = 2'd0;
    case (r.op)
      g2fb_pkg::OP_DRAW: begin
        g  = gray_of(r);
        sx = int'(r.x);
        sy = int'(r.y);
        rsp.gray_level = g;
        if (sx >= 0 && sx < PANEL_WIDTH && sy >= 0 && sy < PANEL_HEIGHT) begin
          pix = sy * PANEL_WIDTH + sx;
          sh  = (3 - (pix % 4)) * 2;
          frame_mirror[pix / 4][sh +: 2] = g;
          rsp.written = 1'b1;
        end
      end
      g2fb_pkg::OP_FILL: begin
        g = gray_of(r);
        rsp.gray_level = g;
        for (int i = 0; i < STORE_BYTES; i++) frame_mirror[i] = {4{g}};
      end
      g2fb_pkg::OP_READ: begin
        a = 2 * int'(r.byte_index);
        if (a + 1 < STORE_BYTES) begin
          w = {frame_mirror[a], frame_mirror[a + 1]};
          for (int i = 0; i < 8; i++) rsp.plane_byte[7 - i] = w[(7 - i) * 2 + r.plane];
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic pixel_req_t req_of(
    input logic [1:0] op, input int x, input int y,
    input int red, input int green, input int blue, input int white,
    input int plane, input int k
  );
    pixel_req_t r;
    r.op = op;
    r.x = x[15:0];
    r.y = y[15:0];
    r.red = red[7:0];
    r.green = green[7:0];
    r.blue = blue[7:0];
    r.white = white[7:0];
    r.plane = plane[0];
    r.byte_index = k[15:0];
    return r;
  endfunction

  // Random channels under a random ceiling, so every gray level shows up
  task automatic random_color(inout pixel_req_t r);
    int lim;
    case ($urandom_range(3))
      0: lim = 42;
      1: lim = 127;
      2: lim = 212;
      default: lim = 255;
    endcase
    r.red   = 8'($urandom_range(lim, 0));
    r.green = 8'($urandom_range(lim, 0));
    r.blue  = 8'($urandom_range(lim, 0));
    r.white = 8'($urandom_range(lim, 0));
    if ($urandom_range(3) == 0) r.white = 8'(lim);
  endtask

  // Queue one phase: a fill so every read lands on written pixels, then a mix
  task automatic queue_random_phase(input int count);
    pixel_req_t r;
    int sel;
    r = req_of(g2fb_pkg::OP_FILL, $urandom, $urandom, 0, 0, 0, 0, $urandom, $urandom);
    random_color(r);
    pending_requests.push_back(r);
    for (int n = 1; n < count; n++) begin
      r = req_of(g2fb_pkg::OP_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
      sel = $urandom_range(99);
      if (sel < 25) begin
        // draw into the small region that the reads watch
        r.x = 16'($urandom_range(63));
        r.y = 16'($urandom_range(3));
        random_color(r);
      end else if (sel < 47) begin
        r.x = 16'($urandom_range(PANEL_WIDTH - 1));
        r.y = 16'($urandom_range(PANEL_HEIGHT - 1));
        random_color(r);
      end else if (sel < 55) begin
        // draw with raw coordinates, mostly off the panel
      end else if (sel < 75) begin
        r.op = g2fb_pkg::OP_READ;
        r.byte_index = 16'($urandom_range(3) * (PANEL_WIDTH / 8) + $urandom_range(7));
      end else if (sel < 91) begin
        r.op = g2fb_pkg::OP_READ;
        r.byte_index = 16'($urandom_range(PLANE_BYTES - 1));
      end else if (sel < 96) begin
        r.op = g2fb_pkg::OP_READ;
        r.byte_index = 16'($urandom_range(16'hFFFF, PLANE_BYTES));
      end else begin
        r.op = OP_UNUSED;
      end
      pending_requests.push_back(r);
    end
  endtask

  // Drive requests at the falling edge; hold one until it is taken
  always @(negedge clk) begin : driver
    pixel_req_t nxt;
    if (rst) begin
      item.valid <= 1'b0;
    end else if (!item.valid || req_fired) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_requests.pop_front();
        item.valid      <= 1'b1;
        item.op         <= nxt.op;
        item.x          <= nxt.x;
        item.y          <= nxt.y;
        item.red        <= nxt.red;
        item.green      <= nxt.green;
        item.blue       <= nxt.blue;
        item.white      <= nxt.white;
        item.plane      <= nxt.plane;
        item.byte_index <= nxt.byte_index;
      end else begin
        item.valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    result.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Record taken requests and check responses at the rising edge
  always @(posedge clk) begin : monitor
    pixel_req_t taken;
    pixel_rsp_t want;
    if (rst) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= item.valid && item.ready;
      if (item.valid && item.ready) begin
        taken.op         = item.op;
        taken.x          = item.x;
        taken.y          = item.y;
        taken.red        = item.red;
        taken.green      = item.green;
        taken.blue       = item.blue;
        taken.white      = item.white;
        taken.plane      = item.plane;
        taken.byte_index = item.byte_index;
        apply_request(taken, want);
        expected_results.push_back(want);
      end
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected response plane_byte=%h written=%b gray_level=%0d",
                   $time, result.plane_byte, result.written, result.gray_level);
        end else begin
          want = expected_results.pop_front();
          if (result.plane_byte !== want.plane_byte) begin
            mismatch_count++;
            $display("%0t: plane_byte expected %h actual %h",
                     $time, want.plane_byte, result.plane_byte);
          end
          if (result.written !== want.written) begin
            mismatch_count++;
            $display("%0t: written expected %b actual %b",
                     $time, want.written, result.written);
          end
          if (result.gray_level !== want.gray_level) begin
            mismatch_count++;
            $display("%0t: gray_level expected %0d actual %0d",
                     $time, want.gray_level, result.gray_level);
          end
        end
      end
    end
  end

  // Timeout
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("gray2_framebuffer_bitplane_engine_core_tb failed");
    $finish;
  end

  initial begin
    item.valid      = 1'b0;
    item.op         = g2fb_pkg::OP_DRAW;
    item.x          = '0;
    item.y          = '0;
    item.red        = '0;
    item.green      = '0;
    item.blue       = '0;
    item.white      = '0;
    item.plane      = 1'b0;
    item.byte_index = '0;
    result.ready    = 1'b0;
    for (int i = 0; i < STORE_BYTES; i++) frame_mirror[i] = 8'd0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: fill first so no read touches unwritten pixels
    pending_requests.push_back(req_of(g2fb_pkg::OP_FILL, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0,
                                      PLANE_BYTES - 1));
    // Quantizer thresholds on each channel
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, 0, 0, 255, 0, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, 1, 0, 0, 0, 0, 128, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, 2, 0, 0, 127, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, 3, 0, 0, 0, 43, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, 4, 0, 42, 0, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, 5, 0, 0, 212, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, 7, 0, 0, 0, 213, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, PANEL_WIDTH - 1, PANEL_HEIGHT - 1,
                                      255, 255, 255, 255, 1, 16'hFFFF));
    // Pixels just off the left, right and bottom edges and at the coordinate extremes
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, -1, 0, 255, 0, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, PANEL_WIDTH, PANEL_HEIGHT - 1,
                                      0, 100, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, PANEL_WIDTH - 1, PANEL_HEIGHT,
                                      0, 0, 200, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, -32768, -32768,
                                      0, 0, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_DRAW, 32767, 32767,
                                      0, 0, 0, 255, 0, 0));
    // Plane reads over the drawn pixels, then past the end of the store
    pending_requests.push_back(req_of(g2fb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1,
                                      PLANE_BYTES - 1));
    pending_requests.push_back(req_of(g2fb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1,
                                      PLANE_BYTES));
    pending_requests.push_back(req_of(g2fb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1, 16'hFFFF));
    // Unused opcode with every field high
    pending_requests.push_back(req_of(OP_UNUSED, -1, -1, 255, 255, 255, 255, 1, 16'hFFFF));
    pending_requests.push_back(req_of(g2fb_pkg::OP_FILL, 0, 0, 0, 128, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(req_of(g2fb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1,
                                      PLANE_BYTES - 1));

    // Random phases: sender idles less than receiver, then the reverse, then none
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      queue_random_phase(PHASE_ITEMS);
      while (pending_requests.size() != 0 || item.valid) @(posedge clk);
    end

    // Drain the remaining responses
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("gray2_framebuffer_bitplane_engine_core_tb passed");
    end else begin
      $display("gray2_framebuffer_bitplane_engine_core_tb failed");
    end
    $finish;
  end

endmodule
